FILE: sv/ppe_pkg.sv
`timescale 1ns / 1ps
package ppe_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam int KIND_W  = 3;
	localparam int VALUE_W = 32;
	localparam int ENTRY_W = KIND_W + VALUE_W;

	localparam logic [KIND_W-1:0] KIND_NUM   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SUB   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_MUL   = 3'd5;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SYNTAX   = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	// Stack slots captured while popping a group, top first.
	localparam logic [1:0] SLOT_RHS = 2'd0;
	localparam logic [1:0] SLOT_OP  = 2'd1;
	localparam logic [1:0] SLOT_LHS = 2'd2;

	typedef struct packed {
		logic       tok_load;
		logic       push_tok;
		logic       set_err;
		logic [1:0] err_val;
		logic       rd_en;
		logic       rd_zero;
		logic [1:0] rd_off;
		logic       cap_en;
		logic [1:0] cap_slot;
		logic       calc_en;
		logic       commit;
		logic       emit;
	} ppe_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              last;
		logic              err_any;
		logic              full;
		logic              lt4;
		logic              depth_one;
		logic              out_free;
	} ppe_sts_t;

endpackage

FILE: sv/parenthesized_expression_evaluator.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// token    tok_valid / tok_stall  token_kind[2:0], token_value[30:0], last_token
// result   res_valid / res_stall  result_value[31:0] (signed), error_code[1:0]
//
// One token at a time. A close paren takes four pops, a group check and the
// operation (add, subtract or multiply), and a result write on the single
// port stack memory. A last token adds a final check.
// The result sits in an output register; the next token is taken while it
// waits, and a following last token holds until the register frees.
// Reset clears depth, error and handshake state; the stack needs no clearing.
module parenthesized_expression_evaluator import ppe_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_stall,
	input  logic [2:0]         token_kind,
	input  logic [30:0]        token_value,
	input  logic               last_token,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] result_value,
	output logic [1:0]         error_code
);

	ppe_cmd_t cmd;
	ppe_sts_t sts;

	ppe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppe_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.token_kind   (token_kind),
		.token_value  (token_value),
		.last_token   (last_token),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_value (result_value),
		.error_code   (error_code)
	);

endmodule

FILE: sv/ppe_ctrl.sv
`timescale 1ns / 1ps
module ppe_ctrl import ppe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tok_valid,
	output logic     tok_stall,
	input  ppe_sts_t sts,
	output ppe_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_GRAB,
		ST_COMMIT,
		ST_FIN,
		ST_FCHK
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q, cnt_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cnt_d     = cnt_q;
		tok_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (tok_valid) begin
					cmd.tok_load = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = sts.last ? ST_FIN : ST_IDLE;
				if (!sts.err_any) begin
					case (sts.kind)
						KIND_NUM, KIND_OPEN, KIND_ADD, KIND_SUB, KIND_MUL: begin
							if (sts.full) begin
								cmd.set_err = 1'b1;
								cmd.err_val = ERR_OVERFLOW;
							end else begin
								cmd.push_tok = 1'b1;
							end
						end
						KIND_CLOSE: begin
							if (sts.lt4) begin
								cmd.set_err = 1'b1;
								cmd.err_val = ERR_SYNTAX;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_off = 2'd0;
								cnt_d      = 2'd1;
								state_d    = ST_POP;
							end
						end
						default: begin
							cmd.set_err = 1'b1;
							cmd.err_val = ERR_SYNTAX;
						end
					endcase
				end
			end
			ST_POP: begin
				// issue the next read, capture the one issued last cycle
				cmd.rd_en    = 1'b1;
				cmd.rd_off   = cnt_q;
				cmd.cap_en   = 1'b1;
				cmd.cap_slot = cnt_q - 2'd1;
				cnt_d        = cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					state_d = ST_GRAB;
			end
			ST_GRAB: begin
				cmd.calc_en = 1'b1;
				state_d     = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sts.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					if (!sts.err_any && sts.depth_one) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_zero = 1'b1;
						state_d     = ST_FCHK;
					end else begin
						cmd.emit = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_FCHK: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: sv/ppe_dp.sv
`timescale 1ns / 1ps
module ppe_dp import ppe_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppe_cmd_t            cmd,
	output ppe_sts_t            sts,
	input  logic [2:0]          token_kind,
	input  logic [30:0]         token_value,
	input  logic                last_token,
	output logic                res_valid,
	input  logic                res_stall,
	output logic signed [31:0]  result_value,
	output logic [1:0]          error_code
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);
	localparam logic [DW-1:0] GROUP     = DW'(4);

	logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

	logic [DW-1:0]      depth_q;
	logic [1:0]         err_q;
	logic [KIND_W-1:0]  kind_q;
	logic [30:0]        value_q;
	logic               last_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] rhs_q, op_q, lhs_q;
	logic [VALUE_W-1:0] calc_q;
	logic               ok_q;
	logic               out_valid_q;
	logic [31:0]        out_value_q;
	logic [1:0]         out_code_q;

	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               wr_en;
	logic [ENTRY_W-1:0] wr_data;
	logic [DW-1:0]      top_off;
	logic [VALUE_W-1:0] prod;
	logic [VALUE_W-1:0] calc_d;
	logic               op_ok;
	logic [1:0]         fin_code;

	logic [KIND_W-1:0]  rhs_kind, op_kind, lhs_kind, open_kind, fin_kind;
	logic [VALUE_W-1:0] rhs_val, lhs_val;

	assign rhs_kind  = rhs_q[ENTRY_W-1 -: KIND_W];
	assign op_kind   = op_q[ENTRY_W-1 -: KIND_W];
	assign lhs_kind  = lhs_q[ENTRY_W-1 -: KIND_W];
	assign open_kind = rd_q[ENTRY_W-1 -: KIND_W];
	assign fin_kind  = rd_q[ENTRY_W-1 -: KIND_W];
	assign rhs_val   = rhs_q[VALUE_W-1:0];
	assign lhs_val   = lhs_q[VALUE_W-1:0];

	assign top_off = depth_q - DW'(1) - DW'(cmd.rd_off);
	assign rd_addr = cmd.rd_zero ? '0 : top_off[AW-1:0];
	assign wr_addr = depth_q[AW-1:0];
	assign wr_en   = cmd.push_tok || (cmd.commit && ok_q);
	assign wr_data = cmd.push_tok
		? {kind_q, (kind_q == KIND_NUM) ? {1'b0, value_q} : 32'd0}
		: {KIND_NUM, calc_q};

	// single-port stack: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[wr_addr] <= wr_data;
		else if (cmd.rd_en)
			rd_q <= stack_mem[rd_addr];
	end

	// low word of the product only
	assign prod = lhs_val * rhs_val;

	always_comb begin
		op_ok  = 1'b1;
		calc_d = '0;
		case (op_kind)
			KIND_ADD: calc_d = lhs_val + rhs_val;
			KIND_SUB: calc_d = lhs_val - rhs_val;
			KIND_MUL: calc_d = prod;
			default:  op_ok  = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.tok_load) begin
			kind_q  <= token_kind;
			value_q <= token_value;
			last_q  <= last_token;
		end
		if (cmd.cap_en) begin
			case (cmd.cap_slot)
				SLOT_RHS: rhs_q <= rd_q;
				SLOT_OP:  op_q  <= rd_q;
				SLOT_LHS: lhs_q <= rd_q;
				default:  lhs_q <= rd_q;
			endcase
		end
		if (cmd.calc_en) begin
			calc_q <= calc_d;
			ok_q   <= op_ok && (open_kind == KIND_OPEN) && (rhs_kind == KIND_NUM)
				&& (lhs_kind == KIND_NUM);
		end
	end

	always_comb begin
		if (err_q != ERR_NONE)
			fin_code = err_q;
		else if (depth_q != DW'(1))
			fin_code = ERR_SYNTAX;
		else if (fin_kind != KIND_NUM)
			fin_code = ERR_SYNTAX;
		else
			fin_code = ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				depth_q     <= '0;
				err_q       <= ERR_NONE;
				out_valid_q <= 1'b1;
			end else begin
				if (!res_stall)
					out_valid_q <= 1'b0;
				if (cmd.set_err)
					err_q <= cmd.err_val;
				if (cmd.push_tok)
					depth_q <= depth_q + DW'(1);
				if (cmd.calc_en)
					depth_q <= depth_q - GROUP;
				if (cmd.commit) begin
					if (ok_q)
						depth_q <= depth_q + DW'(1);
					else
						err_q <= ERR_SYNTAX;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_code_q  <= fin_code;
			out_value_q <= (fin_code == ERR_NONE) ? rd_q[VALUE_W-1:0] : 32'd0;
		end
	end

	assign res_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign error_code   = out_code_q;

	assign sts.kind      = kind_q;
	assign sts.last      = last_q;
	assign sts.err_any   = (err_q != ERR_NONE);
	assign sts.full      = (depth_q >= DEPTH_MAX);
	assign sts.lt4       = (depth_q < GROUP);
	assign sts.depth_one = (depth_q == DW'(1));
	assign sts.out_free  = !out_valid_q || !res_stall;

endmodule

FILE: test/tb_parenthesized_expression_evaluator.sv
`timescale 1ns / 1ps
module tb_parenthesized_expression_evaluator;
	import ppe_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int GROUP_SIZE  = 4;
	localparam int TAIL_CYCLES = 20;

	// kinds outside the token set
	localparam logic [2:0] KIND_BAD_LO = 3'd6;
	localparam logic [2:0] KIND_BAD_HI = 3'd7;

	localparam logic [30:0] VALUE_MAX = 31'h7fff_ffff;

	typedef struct packed {
		logic [2:0]  kind;
		logic [30:0] value;
	} token_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  code;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               tok_valid;
	logic               tok_stall;
	logic [2:0]         token_kind;
	logic [30:0]        token_value;
	logic               last_token;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         error_code;

	// evaluation stack mirror
	logic [2:0]  stk_kind [STACK_DEPTH_DEF];
	logic [31:0] stk_val [STACK_DEPTH_DEF];
	int          stk_depth = 0;
	logic [1:0]  stk_err = ERR_NONE;

	outcome_t pending_results[$];
	token_t   expr_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int items_sent     = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	parenthesized_expression_evaluator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.token_value  (token_value),
		.last_token   (last_token),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_value (result_value),
		.error_code   (error_code)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("parenthesized_expression_evaluator verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
	endtask

	function automatic void stack_push(input logic [2:0] kind, input logic [31:0] value);
		if (stk_depth >= STACK_DEPTH_DEF) begin
			stk_err = ERR_OVERFLOW;
		end else begin
			stk_kind[stk_depth] = kind;
			stk_val[stk_depth]  = value;
			stk_depth++;
		end
	endfunction

	// Applies one accepted token; a last token queues the expected result.
	function automatic void fold_token(input token_t t, input logic last);
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] folded;
		logic [2:0]  op;
		logic        group_ok;
		outcome_t    o;
		if (stk_err == ERR_NONE) begin
			case (t.kind)
				KIND_NUM: stack_push(KIND_NUM, {1'b0, t.value});
				KIND_OPEN, KIND_ADD, KIND_SUB, KIND_MUL: stack_push(t.kind, '0);
				KIND_CLOSE: begin
					if (stk_depth < GROUP_SIZE) begin
						stk_err = ERR_SYNTAX;
					end else begin
						rhs = stk_val[stk_depth-1];
						op  = stk_kind[stk_depth-2];
						lhs = stk_val[stk_depth-3];
						group_ok = stk_kind[stk_depth-4] == KIND_OPEN &&
							stk_kind[stk_depth-1] == KIND_NUM &&
							stk_kind[stk_depth-3] == KIND_NUM;
						stk_depth -= GROUP_SIZE;
						folded = '0;
						case (op)
							KIND_ADD: folded = lhs + rhs;
							KIND_SUB: folded = lhs - rhs;
							KIND_MUL: folded = lhs * rhs;
							default:  group_ok = 1'b0;
						endcase
						if (group_ok)
							stack_push(KIND_NUM, folded);
						else
							stk_err = ERR_SYNTAX;
					end
				end
				default: stk_err = ERR_SYNTAX;
			endcase
		end
		if (last) begin
			o.code  = stk_err;
			o.value = '0;
			if (stk_err == ERR_NONE) begin
				if (stk_depth == 1 && stk_kind[0] == KIND_NUM)
					o.value = stk_val[0];
				else
					o.code = ERR_SYNTAX;
			end
			pending_results.push_back(o);
			stk_depth = 0;
			stk_err   = ERR_NONE;
		end
	endfunction

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n === 1'b1 && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no expression pending", result_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (error_code !== want.code)
					report_mismatch("error_code", {30'd0, error_code}, {30'd0, want.code});
			end
		end
	end

	// Entered and left at a falling edge; valid is left high on exit.
	task automatic send_token(input token_t t, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			tok_valid <= 1'b0;
			@(negedge clk);
		end
		tok_valid   <= 1'b1;
		token_kind  <= t.kind;
		token_value <= t.value;
		last_token  <= last;
		do @(posedge clk); while (tok_stall);
		fold_token(t, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_expression();
		for (int i = 0; i < expr_q.size(); i++)
			send_token(expr_q[i], i == expr_q.size() - 1);
	endtask

	task automatic wait_for_results();
		tok_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic token_t make_token(input logic [2:0] kind, input logic [30:0] value);
		token_t t;
		t.kind  = kind;
		t.value = value;
		return t;
	endfunction

	function automatic logic [30:0] pick_value();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: r = '0;
			1: r = {1'b0, VALUE_MAX};
			2: r = $urandom_range(15);
			3: r = $urandom_range(1000);
			default: ;
		endcase
		return r[30:0];
	endfunction

	function automatic logic [2:0] any_kind();
		logic [31:0] r;
		r = $urandom_range(7);
		return r[2:0];
	endfunction

	function automatic logic [2:0] pick_op();
		case ($urandom_range(2))
			0: return KIND_ADD;
			1: return KIND_SUB;
			default: return KIND_MUL;
		endcase
	endfunction

	function automatic logic [2:0] push_kind();
		case ($urandom_range(4))
			0: return KIND_NUM;
			1: return KIND_OPEN;
			2: return KIND_ADD;
			3: return KIND_SUB;
			default: return KIND_MUL;
		endcase
	endfunction

	function automatic void load_group(input logic [2:0] op, input logic [30:0] lhs,
			input logic [30:0] rhs);
		expr_q = {};
		expr_q.push_back(make_token(KIND_OPEN, '0));
		expr_q.push_back(make_token(KIND_NUM, lhs));
		expr_q.push_back(make_token(op, '0));
		expr_q.push_back(make_token(KIND_NUM, rhs));
		expr_q.push_back(make_token(KIND_CLOSE, '0));
	endfunction

	// Grows a well-formed expression by replacing a random number with a group.
	function automatic void build_expression(input int ops);
		token_t grown[$];
		int     pick;
		expr_q = {};
		expr_q.push_back(make_token(KIND_NUM, pick_value()));
		repeat (ops) begin
			do pick = $urandom_range(expr_q.size() - 1); while (expr_q[pick].kind != KIND_NUM);
			grown = {};
			for (int i = 0; i < expr_q.size(); i++) begin
				if (i == pick) begin
					grown.push_back(make_token(KIND_OPEN, pick_value()));
					grown.push_back(expr_q[i]);
					grown.push_back(make_token(pick_op(), pick_value()));
					grown.push_back(make_token(KIND_NUM, pick_value()));
					grown.push_back(make_token(KIND_CLOSE, pick_value()));
				end else begin
					grown.push_back(expr_q[i]);
				end
			end
			expr_q = grown;
		end
	endfunction

	function automatic void corrupt_expression();
		int     pos;
		int     other;
		token_t held;
		repeat ($urandom_range(1, 2)) begin
			pos = $urandom_range(expr_q.size() - 1);
			case ($urandom_range(2))
				0: expr_q[pos].kind = any_kind();
				1: if (expr_q.size() > 1) expr_q.delete(pos);
				default: begin
					other = $urandom_range(expr_q.size() - 1);
					held = expr_q[pos];
					expr_q[pos] = expr_q[other];
					expr_q[other] = held;
				end
			endcase
		end
	endfunction

	task automatic test_arith_extremes();
		expr_q = {};
		expr_q.push_back(make_token(KIND_NUM, VALUE_MAX));
		send_expression();
		load_group(KIND_MUL, VALUE_MAX, VALUE_MAX);
		send_expression();
		load_group(KIND_SUB, '0, VALUE_MAX);
		send_expression();
		load_group(KIND_ADD, VALUE_MAX, VALUE_MAX);
		send_expression();
		wait_for_results();
	endtask

	task automatic test_syntax_errors();
		// operator slot holds a number
		expr_q = {};
		expr_q.push_back(make_token(KIND_OPEN, '0));
		repeat (3) expr_q.push_back(make_token(KIND_NUM, 31'd1));
		expr_q.push_back(make_token(KIND_CLOSE, '0));
		send_expression();
		// underflow
		expr_q = {};
		expr_q.push_back(make_token(KIND_CLOSE, '0));
		send_expression();
		expr_q = {};
		expr_q.push_back(make_token(KIND_BAD_HI, VALUE_MAX));
		send_expression();
		// final check: lone open paren
		expr_q = {};
		expr_q.push_back(make_token(KIND_OPEN, '0));
		send_expression();
		// error sticks past a valid number
		expr_q = {};
		expr_q.push_back(make_token(KIND_BAD_LO, '0));
		expr_q.push_back(make_token(KIND_NUM, 31'd2));
		send_expression();
		wait_for_results();
	endtask

	task automatic test_stack_overflow();
		// full stack, then a push; later tokens ignored
		expr_q = {};
		repeat (STACK_DEPTH_DEF) expr_q.push_back(make_token(KIND_OPEN, '0));
		expr_q.push_back(make_token(KIND_NUM, 31'd9));
		expr_q.push_back(make_token(KIND_CLOSE, '0));
		expr_q.push_back(make_token(KIND_NUM, 31'd5));
		send_expression();
		// reaches exactly full, reduces, no overflow
		expr_q = {};
		repeat (STACK_DEPTH_DEF - GROUP_SIZE) expr_q.push_back(make_token(KIND_OPEN, '0));
		expr_q.push_back(make_token(KIND_OPEN, '0));
		expr_q.push_back(make_token(KIND_NUM, 31'd1));
		expr_q.push_back(make_token(KIND_ADD, '0));
		expr_q.push_back(make_token(KIND_NUM, 31'd2));
		expr_q.push_back(make_token(KIND_CLOSE, '0));
		send_expression();
		// overflow on the last token itself
		expr_q = {};
		repeat (STACK_DEPTH_DEF + 1) expr_q.push_back(make_token(KIND_NUM, pick_value()));
		send_expression();
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int n_items);
		int stop_at;
		int roll;
		int ops;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			roll = $urandom_range(99);
			ops = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
			if (roll < 70) begin
				build_expression(ops);
			end else if (roll < 87) begin
				build_expression(ops);
				corrupt_expression();
			end else if (roll < 97) begin
				expr_q = {};
				repeat ($urandom_range(1, 8))
					expr_q.push_back(make_token(any_kind(), pick_value()));
			end else begin
				expr_q = {};
				repeat ($urandom_range(58, 72))
					expr_q.push_back(make_token(push_kind(), pick_value()));
				expr_q.push_back(make_token(any_kind(), pick_value()));
			end
			send_expression();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n      <= 1'b0;
		tok_valid   <= 1'b0;
		token_kind  <= KIND_NUM;
		token_value <= '0;
		last_token  <= 1'b0;
		send_idle_pct  = 27;
		recv_stall_pct = 84;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_arith_extremes();
		test_syntax_errors();
		test_stack_overflow();
		test_random_traffic(270);
		send_idle_pct  = 84;
		recv_stall_pct = 27;
		test_random_traffic(270);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(260);

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("parenthesized_expression_evaluator verification clean");
		else
			$display("parenthesized_expression_evaluator verification failed");
		$finish;
	end

endmodule

FILE: parenthesized_expression_evaluator.f
sv/ppe_pkg.sv
sv/ppe_ctrl.sv
sv/ppe_dp.sv
sv/parenthesized_expression_evaluator.sv
test/tb_parenthesized_expression_evaluator.sv
